>>> design/rtpq_pkg.sv
`default_nettype none

package rtpq_pkg;

  localparam int IdW     = 16;
  localparam int RankW   = 16;
  localparam int TkeyW   = 40;
  localparam int StatusW = 2;
  localparam int CountW  = 5;

  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  localparam logic [StatusW-1:0] StatusDone  = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd2;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [RankW-1:0] rank;
    logic [TkeyW-1:0] tkey;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> design/rtpq_cell.sv
`default_nettype none

module rtpq_cell (
  input  wire                 clk_i,
  input  wire                 valid_i,
  input  rtpq_pkg::cell_ctl_t ctl_i,
  input  rtpq_pkg::entry_t    new_entry_i,
  input  rtpq_pkg::entry_t    left_entry_i,
  input  wire                 left_before_i,
  input  rtpq_pkg::entry_t    right_entry_i,
  output rtpq_pkg::entry_t    entry_o,
  output logic                before_o
);

  rtpq_pkg::entry_t entry_q, entry_d;

  // The new request belongs at or ahead of this slot.
  assign before_o = !valid_i
                 || (new_entry_i.rank > entry_q.rank)
                 || ((new_entry_i.rank == entry_q.rank) && (new_entry_i.tkey <= entry_q.tkey));

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (before_o) begin
        entry_d = left_before_i ? left_entry_i : new_entry_i;
      end
    end else if (ctl_i.rem) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

>>> design/rank_time_priority_queue.sv
// Channel   Handshake         Payload
// request   start_i / busy_o  operation_i, new_id_i, new_rank_i, new_time_i
// result    done_o strobe     status_o, entry_count_o, front_valid_o, front_id_o, front_rank_o
//
// A request is taken whenever start_i is high, and its result strobes on the next cycle.
// busy_o stays low, so a request may follow in every cycle.
// All slots compare against the new entry at once and shift by one place together.
// Reset clears the entry count and the result strobe; slot contents are not reset.
// The receiver cannot stall; a result is shown for exactly one cycle.
`default_nettype none

module rank_time_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start_i,
  output logic                            busy_o,
  input  wire                             operation_i,
  input  wire  [rtpq_pkg::IdW-1:0]        new_id_i,
  input  wire  [rtpq_pkg::RankW-1:0]      new_rank_i,
  input  wire  [rtpq_pkg::TkeyW-1:0]      new_time_i,
  output logic                            done_o,
  output logic [rtpq_pkg::StatusW-1:0]    status_o,
  output logic [rtpq_pkg::CountW-1:0]     entry_count_o,
  output logic                            front_valid_o,
  output logic [rtpq_pkg::IdW-1:0]        front_id_o,
  output logic [rtpq_pkg::RankW-1:0]      front_rank_o
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic                           accept;
  logic                           is_full, is_empty;
  rtpq_pkg::cell_ctl_t            ctl;
  rtpq_pkg::entry_t               new_entry;
  rtpq_pkg::entry_t               entries [CAPACITY];
  logic [CAPACITY-1:0]            ahead;
  logic [CW-1:0]                  count_q, count_d;
  logic                           done_q;
  logic [rtpq_pkg::StatusW-1:0]   status_q, status_d;
  logic [CW+rtpq_pkg::CountW-1:0] count_ext;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign is_full  = (count_q == CW'(CAPACITY));
  assign is_empty = (count_q == '0);

  assign new_entry.id   = new_id_i;
  assign new_entry.rank = new_rank_i;
  assign new_entry.tkey = new_time_i;

  assign ctl.ins = accept && (operation_i == rtpq_pkg::OpInsert) && !is_full;
  assign ctl.rem = accept && (operation_i == rtpq_pkg::OpRemove) && !is_empty;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_slot
    rtpq_pkg::entry_t left_entry, right_entry;
    logic             left_before;

    if (k == 0) begin : g_head
      assign left_entry  = new_entry;
      assign left_before = 1'b0;
    end else begin : g_body
      assign left_entry  = entries[k-1];
      assign left_before = ahead[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign right_entry = entries[k];
    end else begin : g_inner
      assign right_entry = entries[k+1];
    end

    rtpq_cell u_cell (
      .clk_i         (clk_i),
      .valid_i       (CW'(k) < count_q),
      .ctl_i         (ctl),
      .new_entry_i   (new_entry),
      .left_entry_i  (left_entry),
      .left_before_i (left_before),
      .right_entry_i (right_entry),
      .entry_o       (entries[k]),
      .before_o      (ahead[k])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = rtpq_pkg::StatusDone;
    if (operation_i == rtpq_pkg::OpRemove) begin
      if (is_empty) begin
        status_d = rtpq_pkg::StatusEmpty;
      end else begin
        count_d = count_q - CW'(1);
      end
    end else begin
      if (is_full) begin
        status_d = rtpq_pkg::StatusFull;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  assign count_ext     = {{rtpq_pkg::CountW{1'b0}}, count_q};
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_count_o = count_ext[rtpq_pkg::CountW-1:0];
  assign front_valid_o = !is_empty;
  assign front_id_o    = is_empty ? '0 : entries[0].id;
  assign front_rank_o  = is_empty ? '0 : entries[0].rank;

endmodule

`default_nettype wire

>>> tb/sv/tb_rtpq_pkg.sv
`timescale 1ns / 1ps

package tb_rtpq_pkg;

  import rtpq_pkg::*;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
    logic               front_valid;
    logic [IdW-1:0]     front_id;
    logic [RankW-1:0]   front_rank;
  } outcome_t;

  class queue_scoreboard;
    int       capacity;
    entry_t   waiting_list[$];
    outcome_t expected_outcomes[$];
    int       error_count;
    int       insert_count;
    int       removal_count;
    int       full_reject_count;
    int       empty_remove_count;
    int       result_count;
    int       peak_depth;

    function new(int depth);
      capacity = depth;
    endfunction

    // Entries are kept front first: higher rank, then earlier time key, and a
    // new entry goes ahead of an existing one with the same rank and time key.
    function void note_request(logic op, entry_t fresh);
      outcome_t want;
      int       pos;
      want = '0;
      want.status = StatusDone;
      pos = 0;
      if (op == OpRemove) begin
        if (waiting_list.size() == 0) begin
          want.status = StatusEmpty;
          empty_remove_count++;
        end else begin
          void'(waiting_list.pop_front());
          removal_count++;
        end
      end else begin
        if (waiting_list.size() >= capacity) begin
          want.status = StatusFull;
          full_reject_count++;
        end else begin
          while (pos < waiting_list.size() &&
                 !(fresh.rank > waiting_list[pos].rank ||
                   (fresh.rank == waiting_list[pos].rank &&
                    fresh.tkey <= waiting_list[pos].tkey))) begin
            pos++;
          end
          waiting_list.insert(pos, fresh);
          insert_count++;
        end
      end
      if (waiting_list.size() > peak_depth) begin
        peak_depth = waiting_list.size();
      end
      want.count = CountW'(waiting_list.size());
      if (waiting_list.size() > 0) begin
        want.front_valid = 1'b1;
        want.front_id    = waiting_list[0].id;
        want.front_rank  = waiting_list[0].rank;
      end
      expected_outcomes.push_back(want);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      error_count++;
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        report($sformatf("result with none pending: status %0d count %0d id %0h rank %0h",
                         got.status, got.count, got.front_id, got.front_rank));
        return;
      end
      want = expected_outcomes.pop_front();
      result_count++;
      if (got.status !== want.status) begin
        report($sformatf("result %0d status %0d, want %0d",
                         result_count, got.status, want.status));
      end
      if (got.count !== want.count) begin
        report($sformatf("result %0d entry_count %0d, want %0d",
                         result_count, got.count, want.count));
      end
      if (got.front_valid !== want.front_valid) begin
        report($sformatf("result %0d front_valid %0b, want %0b",
                         result_count, got.front_valid, want.front_valid));
      end
      if (got.front_id !== want.front_id) begin
        report($sformatf("result %0d front_id %0h, want %0h",
                         result_count, got.front_id, want.front_id));
      end
      if (got.front_rank !== want.front_rank) begin
        report($sformatf("result %0d front_rank %0h, want %0h",
                         result_count, got.front_rank, want.front_rank));
      end
    endtask

    task check_drained();
      if (expected_outcomes.size() != 0) begin
        report($sformatf("%0d results never arrived", expected_outcomes.size()));
      end
    endtask
  endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import rtpq_pkg::*;
  import tb_rtpq_pkg::*;

  localparam int QueueDepth   = 16;
  localparam int RequestTotal = 1600;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               operation_i;
  logic [IdW-1:0]     new_id_i;
  logic [RankW-1:0]   new_rank_i;
  logic [TkeyW-1:0]   new_time_i;
  logic               done_o;
  logic [StatusW-1:0] status_o;
  logic [CountW-1:0]  entry_count_o;
  logic               front_valid_o;
  logic [IdW-1:0]     front_id_o;
  logic [RankW-1:0]   front_rank_o;

  queue_scoreboard board;
  int              sent_count;
  bit              burst_mode;

  rank_time_priority_queue #(
    .CAPACITY(QueueDepth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .operation_i  (operation_i),
    .new_id_i     (new_id_i),
    .new_rank_i   (new_rank_i),
    .new_time_i   (new_time_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .front_valid_o(front_valid_o),
    .front_id_o   (front_id_o),
    .front_rank_o (front_rank_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      board.note_request(operation_i, {new_id_i, new_rank_i, new_time_i});
    end
    if (rst_ni && done_o) begin
      board.check_result({status_o, entry_count_o, front_valid_o, front_id_o, front_rank_o});
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [RankW-1:0] pick_rank();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      return RankW'($urandom_range(0, 3));
    end
    if (roll == 6) begin
      return '1;
    end
    return RankW'($urandom);
  endfunction

  function automatic logic [TkeyW-1:0] pick_time();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      return TkeyW'($urandom_range(0, 4));
    end
    if (roll == 6) begin
      return '1;
    end
    if (roll == 7) begin
      return TkeyW'(64'd202401011200 + 64'($urandom_range(0, 3)));
    end
    return TkeyW'({$urandom, $urandom});
  endfunction

  task automatic send_request(input logic op, input logic [IdW-1:0] id,
                              input logic [RankW-1:0] rank, input logic [TkeyW-1:0] tkey);
    int gap;
    gap = pick_gap();
    start_i     <= 1'b1;
    operation_i <= op;
    new_id_i    <= id;
    new_rank_i  <= rank;
    new_time_i  <= tkey;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent_count++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_request(input int insert_percent);
    logic op;
    op = ($urandom_range(0, 99) < insert_percent) ? OpInsert : OpRemove;
    send_request(op, IdW'($urandom), pick_rank(), pick_time());
  endtask

  initial begin
    int phase_len;
    int insert_percent;
    int guard;
    board       = new(QueueDepth);
    sent_count  = 0;
    burst_mode  = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    operation_i = OpInsert;
    new_id_i    = '0;
    new_rank_i  = '0;
    new_time_i  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(OpRemove, 16'h0001, 16'h0001, 40'd1);
    send_request(OpInsert, 16'h0001, 16'd5, 40'd100);
    send_request(OpInsert, 16'h0002, 16'd5, 40'd100);
    send_request(OpInsert, 16'h0003, 16'd5, 40'd99);
    send_request(OpInsert, 16'h0004, 16'd5, 40'd101);
    send_request(OpInsert, 16'hFFFF, 16'hFFFF, 40'hFF_FFFF_FFFF);
    send_request(OpInsert, 16'h0000, 16'h0000, 40'd0);
    send_request(OpInsert, 16'h5A5A, 16'hFFFF, 40'd0);
    repeat (QueueDepth - 7) begin
      send_request(OpInsert, IdW'($urandom), pick_rank(), pick_time());
    end
    send_request(OpInsert, 16'hA5A5, 16'hFFFF, 40'd0);
    repeat (3) send_request(OpRemove, '0, '0, '0);

    // Fill, drain and mixed phases follow in random order so the list reaches both full
    // and empty many times with random contents in between.
    while (sent_count < RequestTotal) begin
      case ($urandom_range(0, 2))
        0: insert_percent = 85;
        1: insert_percent = 15;
        default: insert_percent = 50;
      endcase
      burst_mode = ($urandom_range(0, 3) == 0);
      phase_len  = $urandom_range(8, 40);
      repeat (phase_len) send_random_request(insert_percent);
    end
    start_i <= 1'b0;

    guard = 0;
    while (board.expected_outcomes.size() != 0 && guard < 100) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (3) @(posedge clk_i);
    board.check_drained();

    $display("Ran %0d requests and checked %0d results, deepest list %0d of %0d.",
             sent_count, board.result_count, board.peak_depth, QueueDepth);
    $display("Inserts %0d, front removals %0d, rejected when full %0d, removals on empty %0d.",
             board.insert_count, board.removal_count, board.full_reject_count,
             board.empty_remove_count);
    if (board.error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout after %0d requests.", sent_count);
    $display("Test completed with failures");
    $finish;
  end

endmodule
